// ----- hdl/ira_pkg.sv -----
// ----------------------------------------------------------------------------
// ira_pkg
// Shared types and constants of the integer reduction ALU.
// ----------------------------------------------------------------------------
package ira_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int MODE_W     = 4;
  localparam int SHAMT_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CNT_W      = $clog2(DATA_WIDTH);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT = 1'b1;

  // Operation codes
  localparam logic [MODE_W-1:0] OP_ADD  = 4'd0;
  localparam logic [MODE_W-1:0] OP_SUB  = 4'd1;
  localparam logic [MODE_W-1:0] OP_MUL  = 4'd2;
  localparam logic [MODE_W-1:0] OP_DIV  = 4'd3;
  localparam logic [MODE_W-1:0] OP_MOD  = 4'd4;
  localparam logic [MODE_W-1:0] OP_AND  = 4'd5;
  localparam logic [MODE_W-1:0] OP_OR   = 4'd6;
  localparam logic [MODE_W-1:0] OP_XOR  = 4'd7;
  localparam logic [MODE_W-1:0] OP_SHL  = 4'd8;
  localparam logic [MODE_W-1:0] OP_SHR  = 4'd9;
  localparam logic [MODE_W-1:0] OP_MAX  = 4'd10;
  localparam logic [MODE_W-1:0] OP_MIN  = 4'd11;
  localparam logic [MODE_W-1:0] OP_COND = 4'd12;

  // One classified item as it travels from the front end to the back end
  typedef struct packed {
    logic [MODE_W-1:0]     op;
    logic                  start;   // first item of a set: load init value
    logic                  has;     // element is applied
    logic                  last;    // set closes, emit the result
    logic                  div;     // needs the iterative divider
    logic [DATA_WIDTH-1:0] value;
  } ira_item_t;

endpackage

// ----- hdl/integer_reduction_alu.sv -----
// ----------------------------------------------------------------------------
// integer_reduction_alu
// Folds a stream of signed values into one accumulator with a configured
// operation and emits the accumulator on the last item of each set.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  in_      slave      in_tvalid/tready    tdata value, tuser has_value, tlast
//  out_     master     out_tvalid/tready   tdata result
//  cfg_     slave      cfg_valid/ready     cfg_index register, cfg_data value
//
// Most operations retire one item per cycle in the back end.
// Divide and modulo with a nonzero element occupy the back end while it
// loads, retires one quotient bit per cycle and writes back.
// A two-entry queue lets the input keep accepting while the divider runs.
// Reset is synchronous and active low; it clears the configuration to zero.
// A closing item waits in the queue while the output register is full.
// ----------------------------------------------------------------------------
module integer_reduction_alu import ira_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DATA_WIDTH-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_WIDTH-1:0] in_tdata,   // [31:0] value
  input  logic                  in_tuser,   // [0] has_value
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_WIDTH-1:0] out_tdata   // [31:0] result
);

  logic                  q_push;
  logic                  q_full;
  logic                  q_pop;
  logic                  q_valid;
  ira_item_t             wr_item;
  ira_item_t             rd_item;
  logic [DATA_WIDTH-1:0] init_value;

  ira_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (wr_item),
    .init_value (init_value)
  );

  ira_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_item  (wr_item),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_item  (rd_item)
  );

  ira_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (rd_item),
    .q_pop      (q_pop),
    .init_value (init_value),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- hdl/ira_front.sv -----
// ----------------------------------------------------------------------------
// ira_front
// Holds the configuration registers, tracks set boundaries and classifies
// each accepted request into a queue item.
// ----------------------------------------------------------------------------
module ira_front import ira_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [DATA_WIDTH-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_WIDTH-1:0] in_tdata,
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  input  logic                  q_full,
  output logic                  q_push,
  output ira_item_t             q_item,
  output logic [DATA_WIDTH-1:0] init_value
);

  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [DATA_WIDTH-1:0] init_r, init_nxt;
  logic                  in_set_r, in_set_nxt;
  logic                  is_divop;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !q_full;
  assign q_push     = in_tvalid && in_tready;
  assign init_value = init_r;

  assign is_divop = (mode_r == OP_DIV) || (mode_r == OP_MOD);

  always_comb begin
    q_item.op    = mode_r;
    q_item.start = !in_set_r;
    q_item.has   = in_tuser;
    q_item.last  = in_tlast;
    // Division by zero keeps the accumulator and stays on the fast path.
    q_item.div   = is_divop && in_tuser && (in_tdata != '0);
    q_item.value = in_tdata;
  end

  always_comb begin
    mode_nxt   = mode_r;
    init_nxt   = init_r;
    in_set_nxt = in_set_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE: mode_nxt = cfg_data[MODE_W-1:0];
        REG_INIT: init_nxt = cfg_data;
        default:  ;
      endcase
    end
    if (q_push) begin
      in_set_nxt = !in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= '0;
      init_r   <= '0;
      in_set_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      init_r   <= init_nxt;
      in_set_r <= in_set_nxt;
    end
  end

endmodule

// ----- hdl/ira_fifo.sv -----
// ----------------------------------------------------------------------------
// ira_fifo
// Short queue of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
module ira_fifo import ira_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  ira_item_t wr_item,
  output logic      full,
  input  logic      pop,
  output logic      rd_valid,
  output ira_item_t rd_item
);

  ira_item_t           entry_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;

  assign full     = (count_r == QCNT_W'(QDEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> rd_valid)
    else $error("queue read while empty");

endmodule

// ----- hdl/ira_back.sv -----
// ----------------------------------------------------------------------------
// ira_back
// Executes queued items on the accumulator: single-cycle ALU operations and
// a restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ira_back import ira_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  ira_item_t             q_item,
  output logic                  q_pop,
  input  logic [DATA_WIDTH-1:0] init_value,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_WIDTH-1:0] out_tdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_data_r, out_data_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] den_r, den_nxt;
  logic                  neg_q_r, neg_q_nxt;
  logic                  neg_r_r, neg_r_nxt;
  logic                  is_mod_r, is_mod_nxt;
  logic                  pend_last_r, pend_last_nxt;

  logic                  out_free;
  logic [DATA_WIDTH-1:0] acc_base;
  logic [DATA_WIDTH-1:0] v;
  logic [SHAMT_W-1:0]    shamt;
  logic [DATA_WIDTH-1:0] mul_lo;
  logic [DATA_WIDTH-1:0] alu_res;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH-1:0] div_res;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign v        = q_item.value;
  assign shamt    = v[SHAMT_W-1:0];
  assign acc_base = q_item.start ? init_value : acc_r;
  assign mul_lo   = acc_base * v;

  // A last item waits until the output register can take its result.
  assign q_pop = q_valid && (state_r == ST_IDLE) && (out_free || !q_item.last);

  always_comb begin
    unique case (q_item.op)
      OP_ADD:  alu_res = acc_base + v;
      OP_SUB:  alu_res = acc_base - v;
      OP_MUL:  alu_res = mul_lo;
      OP_AND:  alu_res = acc_base & v;
      OP_OR:   alu_res = acc_base | v;
      OP_XOR:  alu_res = acc_base ^ v;
      OP_SHL:  alu_res = acc_base << shamt;
      OP_SHR:  alu_res = DATA_WIDTH'($signed(acc_base) >>> shamt);
      OP_MAX:  alu_res = ($signed(acc_base) > $signed(v)) ? acc_base : v;
      OP_MIN:  alu_res = ($signed(v) > $signed(acc_base)) ? acc_base : v;
      OP_COND: alu_res = (v != '0) ? v : acc_base;
      default: alu_res = acc_base;
    endcase
  end

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign shifted = {rem_r, quo_r[DATA_WIDTH-1]};
  assign trial   = shifted - {1'b0, den_r};

  always_comb begin
    if (is_mod_r) begin
      div_res = neg_r_r ? (~rem_r + 1'b1) : rem_r;
    end else begin
      div_res = neg_q_r ? (~quo_r + 1'b1) : quo_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    den_nxt       = den_r;
    neg_q_nxt     = neg_q_r;
    neg_r_nxt     = neg_r_r;
    is_mod_nxt    = is_mod_r;
    pend_last_nxt = pend_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          if (q_item.div) begin
            rem_nxt       = '0;
            quo_nxt       = acc_base[DATA_WIDTH-1] ? (~acc_base + 1'b1) : acc_base;
            den_nxt       = v[DATA_WIDTH-1] ? (~v + 1'b1) : v;
            neg_q_nxt     = acc_base[DATA_WIDTH-1] ^ v[DATA_WIDTH-1];
            neg_r_nxt     = acc_base[DATA_WIDTH-1];
            is_mod_nxt    = (q_item.op == OP_MOD);
            pend_last_nxt = q_item.last;
            cnt_nxt       = CNT_W'(DATA_WIDTH - 1);
            state_nxt     = ST_DIV;
          end else begin
            acc_nxt = q_item.has ? alu_res : acc_base;
            if (q_item.last) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = acc_nxt;
            end
          end
        end
      end
      ST_DIV: begin
        if (!trial[DATA_WIDTH]) begin
          rem_nxt = trial[DATA_WIDTH-1:0];
          quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[DATA_WIDTH-1:0];
          quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!pend_last_r || out_free) begin
          acc_nxt   = div_res;
          state_nxt = ST_IDLE;
          if (pend_last_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = div_res;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    cnt_r       <= cnt_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    den_r       <= den_nxt;
    neg_q_r     <= neg_q_nxt;
    neg_r_r     <= neg_r_nxt;
    is_mod_r    <= is_mod_nxt;
    pend_last_r <= pend_last_nxt;
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == ST_IDLE)
    else $error("item taken while the divider is busy");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && (cnt_r == '0) |=> state_r == ST_FIN)
    else $error("divider did not finish after its last step");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |->
      $past(q_pop && q_item.last && !q_item.div) ||
      $past((state_r == ST_FIN) && pend_last_r))
    else $error("result raised without a closing item");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_item.div |=> state_r == ST_DIV)
    else $error("divide item did not start the divider");

endmodule

// ----- tb/tb_integer_reduction_alu.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_reduction_alu
// Self-checking bench for the integer fold reduction. A queue-fed driver
// offers elements under random gaps, a monitor predicts each set's final
// accumulator as its items are accepted, and compares every emitted result
// in order. Directed sets cover wraparound, division corner cases, shift
// masking and every operation code; random phases vary idling on both sides,
// and a closing phase adds a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_integer_reduction_alu;
  import ira_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 4 * (DATA_WIDTH + 2);
  localparam int HOLD_CYCLES  = 400;
  localparam logic [MODE_W-1:0] OP_UNUSED_HI = 4'd15;
  localparam logic [DATA_WIDTH-1:0] MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  typedef struct packed {
    logic [DATA_WIDTH-1:0] value;
    logic                  has;
    logic                  last;
  } fold_req_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [DATA_WIDTH-1:0] cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [DATA_WIDTH-1:0] in_tdata;
  logic                  in_tuser;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [DATA_WIDTH-1:0] out_tdata;

  fold_req_t             pend_q[$];
  logic [DATA_WIDTH-1:0] fold_results_q[$];
  logic [MODE_W-1:0]     cur_mode;
  logic [DATA_WIDTH-1:0] cur_init;
  logic [DATA_WIDTH-1:0] acc_track = '0;
  logic                  set_open = 1'b0;
  logic                  in_took = 1'b0;
  logic                  cfg_took = 1'b0;
  logic                  hold_go;
  logic                  hold_rx = 1'b0;
  int                    in_accepted = 0;
  int                    items_queued;
  int                    send_idle_pct;
  int                    stall_pct;
  int                    fault_cnt = 0;
  int                    cycle_cnt = 0;

  integer_reduction_alu DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // One element folded into the running accumulator.
  function automatic logic [DATA_WIDTH-1:0] fold_elem(input logic [MODE_W-1:0] op,
                                                      input logic [DATA_WIDTH-1:0] acc,
                                                      input logic [DATA_WIDTH-1:0] v);
    logic signed [DATA_WIDTH-1:0] sa;
    logic signed [DATA_WIDTH-1:0] sv;
    logic [SHAMT_W-1:0]           sh;
    sa = acc;
    sv = v;
    sh = v[SHAMT_W-1:0];
    case (op)
      OP_ADD:  return acc + v;
      OP_SUB:  return acc - v;
      OP_MUL:  return acc * v;
      OP_DIV: begin
        if (v == '0) return acc;
        if (acc == MOST_NEG && v == '1) return MOST_NEG;
        return sa / sv;
      end
      OP_MOD: begin
        if (v == '0) return acc;
        if (acc == MOST_NEG && v == '1) return '0;
        return sa % sv;
      end
      OP_AND:  return acc & v;
      OP_OR:   return acc | v;
      OP_XOR:  return acc ^ v;
      OP_SHL:  return acc << sh;
      OP_SHR:  return sa >>> sh;
      OP_MAX:  return (sa > sv) ? acc : v;
      OP_MIN:  return (sv > sa) ? acc : v;
      OP_COND: return (v != '0) ? v : acc;
      default: return acc;
    endcase
  endfunction

  function automatic logic [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(9))
      0:       return MOST_NEG;
      1:       return MOST_POS;
      2:       return '0;
      3:       return '1;
      4:       return DATA_WIDTH'($urandom_range(1, 40));
      5:       return -DATA_WIDTH'($urandom_range(1, 40));
      default: return DATA_WIDTH'($urandom());
    endcase
  endfunction

  task automatic note_fault(input string what, input logic [DATA_WIDTH-1:0] want,
                            input logic [DATA_WIDTH-1:0] got);
    if (fault_cnt < 10)
      $display("[%0t] %s: expected %h, got %h", $realtime, what, want, got);
    fault_cnt++;
  endtask

  task automatic send(input logic [DATA_WIDTH-1:0] v, input logic has, input logic last);
    pend_q.push_back('{v, has, last});
    items_queued++;
  endtask

  // Wait until every request is taken, every result is back, and any
  // trailing element without a result has left the divider.
  task automatic quiesce();
    while (in_accepted != items_queued || fold_results_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_WIDTH-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    while (!cfg_took) @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_MODE) cur_mode = data[MODE_W-1:0];
    else cur_init = data;
  endtask

  task automatic program_fold(input logic [MODE_W-1:0] op, input logic [DATA_WIDTH-1:0] init);
    quiesce();
    write_reg(REG_MODE, DATA_WIDTH'(op));
    write_reg(REG_INIT, init);
  endtask

  // Mostly short sets, a few long ones; the final set may stay open so that
  // the next configuration lands in the middle of it.
  task automatic gen_sets(input int budget);
    int   n;
    int   len;
    logic closing;
    n = 0;
    while (n < budget) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
      closing = (n + len < budget) || ($urandom_range(9) >= 3);
      for (int k = 0; k < len; k++)
        send(pick_value(), $urandom_range(9) != 0, (k == len - 1) && closing);
      n += len;
    end
  endtask

  // Driver: a request stays on the bus until it is taken.
  always @(negedge clk) begin : drv
    fold_req_t nxt;
    if (rst_n && (!in_tvalid || in_took)) begin
      if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pend_q.pop_front();
        in_tdata  <= nxt.value;
        in_tuser  <= nxt.has;
        in_tlast  <= nxt.last;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= !hold_rx && ($urandom_range(99) >= stall_pct);
  end

  // Long receiver hold-off so the block backs up and stalls its input.
  initial begin : rx_hold
    wait (hold_go === 1'b1);
    @(posedge clk);
    hold_rx = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx = 1'b0;
  end

  // Monitor: predict on each accepted request, check each accepted result.
  always @(posedge clk) begin : mon
    logic [DATA_WIDTH-1:0] want;
    cycle_cnt++;
    in_took  <= rst_n && in_tvalid && in_tready;
    cfg_took <= rst_n && cfg_valid && cfg_ready;
    if (rst_n && in_tvalid && in_tready) begin
      if (!set_open) begin
        acc_track = cur_init;
        set_open  = 1'b1;
      end
      if (in_tuser) acc_track = fold_elem(cur_mode, acc_track, in_tdata);
      if (in_tlast) begin
        fold_results_q.push_back(acc_track);
        set_open = 1'b0;
      end
      in_accepted <= in_accepted + 1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (fold_results_q.size() == 0) begin
        note_fault("unexpected result", '0, out_tdata);
      end else begin
        want = fold_results_q.pop_front();
        if (out_tdata !== want) note_fault("result mismatch", want, out_tdata);
      end
    end
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("tb_integer_reduction_alu NOT OK");
      $finish;
    end
  end

  initial begin : main
    int phase;
    int seg;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    in_tlast      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_MODE;
    cfg_data      = '0;
    out_tready    = 1'b0;
    cur_mode      = OP_ADD;
    cur_init      = '0;
    hold_go       = 1'b0;
    items_queued  = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Empty set under reset configuration returns the reset init value.
    send('0, 1'b0, 1'b1);
    program_fold(OP_ADD, MOST_POS);
    send(1, 1'b1, 1'b1);
    program_fold(OP_SUB, MOST_NEG);
    send(1, 1'b1, 1'b0);
    send('0, 1'b0, 1'b1);
    program_fold(OP_MUL, 32'h0001_0000);
    send(32'h0001_0000, 1'b1, 1'b1);
    // Most negative over minus one wraps; then divide by zero keeps it.
    program_fold(OP_DIV, MOST_NEG);
    send('1, 1'b1, 1'b0);
    send('0, 1'b1, 1'b1);
    program_fold(OP_DIV, -7);
    send(2, 1'b1, 1'b1);
    program_fold(OP_MOD, -7);
    send('0, 1'b1, 1'b0);
    send(2, 1'b1, 1'b1);
    program_fold(OP_MOD, MOST_NEG);
    send('1, 1'b1, 1'b1);
    program_fold(OP_AND, '1);
    send(32'h5A5A_A5A5, 1'b1, 1'b1);
    program_fold(OP_OR, '0);
    send(32'hA5A5_5A5A, 1'b1, 1'b0);
    send(32'h5A5A_A5A5, 1'b1, 1'b1);
    program_fold(OP_XOR, '1);
    send('1, 1'b1, 1'b1);
    // Shift amounts use only the low five bits.
    program_fold(OP_SHL, 3);
    send(33, 1'b1, 1'b0);
    send('1, 1'b1, 1'b1);
    program_fold(OP_SHR, MOST_NEG);
    send(31, 1'b1, 1'b1);
    program_fold(OP_SHR, MOST_POS);
    send(32'hFFFF_FFE4, 1'b1, 1'b1);
    program_fold(OP_MAX, MOST_NEG);
    send(MOST_POS, 1'b1, 1'b0);
    send('1, 1'b1, 1'b1);
    program_fold(OP_MIN, MOST_POS);
    send(MOST_NEG, 1'b1, 1'b0);
    send(5, 1'b1, 1'b1);
    program_fold(OP_COND, 42);
    send('0, 1'b1, 1'b0);
    send(-9, 1'b1, 1'b1);
    program_fold(OP_UNUSED_HI, 7);
    send(123, 1'b1, 1'b1);
    // A mode change inside an open set applies to the next element only,
    // and a new init value waits for the next set.
    program_fold(OP_ADD, 10);
    send(5, 1'b1, 1'b0);
    program_fold(OP_MUL, 99);
    send(3, 1'b1, 1'b1);

    for (phase = 0; phase < 4; phase++) begin
      quiesce();
      @(posedge clk);
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 70; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 70; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      for (seg = 0; seg < 8; seg++) begin
        program_fold(MODE_W'(phase * 8 + seg), pick_value());
        gen_sets(55);
      end
    end

    // Back-pressure: the sender keeps offering while the receiver holds off.
    program_fold(OP_ADD, pick_value());
    @(posedge clk);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_go       = 1'b1;
    for (int k = 0; k < 80; k++)
      send(pick_value(), $urandom_range(7) != 0, $urandom_range(3) != 0);
    send(pick_value(), 1'b1, 1'b1);

    while (in_accepted != items_queued || fold_results_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fault_cnt == 0 && fold_results_q.size() == 0) begin
      $display("tb_integer_reduction_alu OK");
    end else begin
      $display("tb_integer_reduction_alu NOT OK");
    end
    $finish;
  end

endmodule
